>>> hw/rtl/wavhp_pkg.sv
// Shared types, tags and codes for the WAV header parser.
`timescale 1ns / 1ps

package wavhp_pkg;

    // Chunk and file tags, first byte of the stream in the top byte
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_FACT = 32'h6661_6374;
    localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [31:0] FMT_MIN_LEN = 32'd16;
    localparam logic [7:0]  PCM_CODE    = 8'd1;
    localparam logic [31:0] ID_LEN      = 32'd4;

    // fmt body byte positions that carry captured fields
    localparam logic [3:0] FMT_CODE_LO = 4'd0;
    localparam logic [3:0] FMT_CODE_HI = 4'd1;
    localparam logic [3:0] FMT_CH_LO   = 4'd2;
    localparam logic [3:0] FMT_CH_HI   = 4'd3;
    localparam logic [3:0] FMT_RATE_B0 = 4'd4;
    localparam logic [3:0] FMT_RATE_B1 = 4'd5;
    localparam logic [3:0] FMT_RATE_B2 = 4'd6;
    localparam logic [3:0] FMT_RATE_B3 = 4'd7;
    localparam logic [3:0] FMT_BITS_LO = 4'd14;
    localparam logic [3:0] FMT_BITS_HI = 4'd15;

    typedef enum logic [8:0] {
        PH_RIFF    = 9'b0_0000_0001,
        PH_RIFFLEN = 9'b0_0000_0010,
        PH_WAVE    = 9'b0_0000_0100,
        PH_ID      = 9'b0_0000_1000,
        PH_LEN     = 9'b0_0001_0000,
        PH_SKIP    = 9'b0_0010_0000,
        PH_FMT     = 9'b0_0100_0000,
        PH_PAYLOAD = 9'b0_1000_0000,
        PH_ERROR   = 9'b1_0000_0000
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_NOT_RIFF    = 3'd1,
        ERR_NOT_WAVE    = 3'd2,
        ERR_UNSUPPORTED = 3'd3,
        ERR_FMT_SHORT   = 3'd4,
        ERR_NOT_PCM     = 3'd5,
        ERR_EARLY_END   = 3'd6
    } err_t;

    typedef enum logic [1:0] {
        STAGE_HEADER  = 2'd0,
        STAGE_PAYLOAD = 2'd1,
        STAGE_ERROR   = 2'd2
    } stage_t;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] field_counter;
        logic [31:0] tag_shift;
        logic [31:0] chunk_length;
        logic        fmt_seen;
        logic [15:0] held_channels;
        logic [31:0] held_rate;
        logic [15:0] held_bits;
        logic [31:0] held_data_length;
        err_t        held_error;
    } state_t;

    typedef struct packed {
        stage_t      stage;
        err_t        error_code;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [15:0] sample_bits;
        logic [31:0] data_length;
        logic        payload_valid;
        logic [7:0]  payload_byte;
    } result_t;

    localparam state_t STATE_RESET = '{
        PH_RIFF, 32'd0, 32'd0, 32'd0, 1'b0,
        16'd0, 32'd0, 16'd0, 32'd0, ERR_NONE
    };

endpackage

>>> hw/rtl/wavhp_next.sv
// Per-byte next-state and result logic of the WAV header parser.
`timescale 1ns / 1ps

module wavhp_next (
    input  wavhp_pkg::state_t  cur,
    input  logic [7:0]         in_byte,
    input  logic               end_of_stream,
    output wavhp_pkg::state_t  nxt,
    output wavhp_pkg::result_t res
);
    import wavhp_pkg::*;

    logic [31:0] cnt_inc;
    logic [31:0] len_shift;
    logic [31:0] fmt_rest;
    logic [3:0]  fmt_idx;
    logic        pv;
    state_t      upd;

    assign cnt_inc   = cur.field_counter + 32'd1;
    assign len_shift = {in_byte, cur.chunk_length[31:8]};
    assign fmt_rest  = cur.chunk_length - FMT_MIN_LEN;
    assign fmt_idx   = cur.field_counter[3:0];

    // State update for one byte
    always_comb
    begin
        upd = cur;
        pv  = 1'b0;
        unique case (cur.phase)
            PH_RIFF, PH_WAVE, PH_ID:
            begin
                upd.tag_shift     = {cur.tag_shift[23:0], in_byte};
                upd.field_counter = cnt_inc;
                if (cnt_inc >= ID_LEN)
                begin
                    upd.field_counter = 32'd0;
                    if (cur.phase == PH_RIFF)
                    begin
                        if (upd.tag_shift == TAG_RIFF)
                        begin
                            upd.phase = PH_RIFFLEN;
                        end
                        else
                        begin
                            upd.held_error = ERR_NOT_RIFF;
                            upd.phase      = PH_ERROR;
                        end
                    end
                    else if (cur.phase == PH_WAVE)
                    begin
                        if (upd.tag_shift == TAG_WAVE)
                        begin
                            upd.phase = PH_ID;
                        end
                        else
                        begin
                            upd.held_error = ERR_NOT_WAVE;
                            upd.phase      = PH_ERROR;
                        end
                    end
                    else
                    begin
                        upd.phase = PH_LEN;
                    end
                end
            end
            PH_RIFFLEN:
            begin
                upd.field_counter = cnt_inc;
                if (cnt_inc >= ID_LEN)
                begin
                    upd.field_counter = 32'd0;
                    upd.phase         = PH_WAVE;
                end
            end
            PH_LEN:
            begin
                upd.chunk_length  = len_shift;
                upd.field_counter = cnt_inc;
                if (cnt_inc >= ID_LEN)
                begin
                    upd.field_counter = 32'd0;
                    // chunk header complete: id in tag_shift, length in len_shift
                    if (!cur.fmt_seen)
                    begin
                        if (cur.tag_shift == TAG_FMT)
                        begin
                            if (len_shift < FMT_MIN_LEN)
                            begin
                                upd.held_error = ERR_FMT_SHORT;
                                upd.phase      = PH_ERROR;
                            end
                            else
                            begin
                                upd.fmt_seen = 1'b1;
                                upd.phase    = PH_FMT;
                            end
                        end
                        else if (cur.tag_shift == TAG_FACT || cur.tag_shift == TAG_LIST)
                        begin
                            upd.phase = (len_shift != 32'd0) ? PH_SKIP : PH_ID;
                        end
                        else
                        begin
                            upd.held_error = ERR_UNSUPPORTED;
                            upd.phase      = PH_ERROR;
                        end
                    end
                    else if (cur.tag_shift == TAG_DATA)
                    begin
                        upd.held_data_length = len_shift;
                        upd.phase            = PH_PAYLOAD;
                    end
                    else
                    begin
                        upd.phase = (len_shift != 32'd0) ? PH_SKIP : PH_ID;
                    end
                end
            end
            PH_SKIP:
            begin
                upd.field_counter = cnt_inc;
                if (cnt_inc >= cur.chunk_length)
                begin
                    upd.field_counter = 32'd0;
                    upd.phase         = PH_ID;
                end
            end
            PH_FMT:
            begin
                upd.field_counter = cnt_inc;
                unique case (fmt_idx)
                    FMT_CODE_LO: upd.tag_shift = {24'd0, in_byte};
                    FMT_CODE_HI:
                    begin
                        if (!(cur.tag_shift == {24'd0, PCM_CODE} && in_byte == 8'd0))
                        begin
                            upd.field_counter = cur.field_counter;
                            upd.held_error    = ERR_NOT_PCM;
                            upd.phase         = PH_ERROR;
                        end
                    end
                    FMT_CH_LO:   upd.held_channels = cur.held_channels | {8'd0, in_byte};
                    FMT_CH_HI:   upd.held_channels = cur.held_channels | {in_byte, 8'd0};
                    FMT_RATE_B0: upd.held_rate = cur.held_rate | {24'd0, in_byte};
                    FMT_RATE_B1: upd.held_rate = cur.held_rate | {16'd0, in_byte, 8'd0};
                    FMT_RATE_B2: upd.held_rate = cur.held_rate | {8'd0, in_byte, 16'd0};
                    FMT_RATE_B3: upd.held_rate = cur.held_rate | {in_byte, 24'd0};
                    FMT_BITS_LO: upd.held_bits = cur.held_bits | {8'd0, in_byte};
                    FMT_BITS_HI: upd.held_bits = cur.held_bits | {in_byte, 8'd0};
                    default:     upd.field_counter = cnt_inc;
                endcase
                // end of the 16 standard fmt bytes: skip any extension
                if (upd.phase == PH_FMT && cnt_inc == FMT_MIN_LEN)
                begin
                    upd.chunk_length  = fmt_rest;
                    upd.field_counter = 32'd0;
                    upd.phase         = (fmt_rest != 32'd0) ? PH_SKIP : PH_ID;
                end
            end
            PH_PAYLOAD:
            begin
                pv = 1'b1;
            end
            PH_ERROR:
            begin
                upd.phase = PH_ERROR;
            end
            default:
            begin
                upd.phase = cur.phase;
            end
        endcase

        // end of stream inside the header
        if (end_of_stream && upd.phase != PH_PAYLOAD && upd.phase != PH_ERROR)
        begin
            upd.held_error = ERR_EARLY_END;
            upd.phase      = PH_ERROR;
        end
    end

    // Result of this byte and state for the next one
    always_comb
    begin
        if (pv)
        begin
            res.stage = STAGE_PAYLOAD;
        end
        else if (upd.phase == PH_ERROR)
        begin
            res.stage = STAGE_ERROR;
        end
        else
        begin
            res.stage = STAGE_HEADER;
        end
        res.error_code    = (res.stage == STAGE_ERROR) ? upd.held_error : ERR_NONE;
        res.channel_count = upd.held_channels;
        res.sample_rate   = upd.held_rate;
        res.sample_bits   = upd.held_bits;
        res.data_length   = upd.held_data_length;
        res.payload_valid = pv;
        res.payload_byte  = pv ? in_byte : 8'd0;

        nxt = end_of_stream ? STATE_RESET : upd;
    end

endmodule

>>> hw/rtl/wavhp_out_reg.sv
// Result register with valid/ready handshake toward the consumer.
`timescale 1ns / 1ps

module wavhp_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  wavhp_pkg::result_t res_in,
    input  logic               out_ready,
    output logic               out_valid,
    output logic               take_ok,
    output wavhp_pkg::result_t res_out
);
    import wavhp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Slot is free when empty or drained this cycle
    assign take_ok    = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload captured on each input transfer
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = result_reg;

endmodule

>>> hw/rtl/wav_header_parser_core.sv
// Top level of the byte-serial RIFF/WAVE PCM header parser.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_ready  | in_byte, end_of_stream
//  output  | out_valid / out_ready| stage, error_code, channel_count,
//          |                      | sample_rate, sample_bits, data_length,
//          |                      | payload_valid, payload_byte
//
// One byte per clock while in_ready is high: each transfer updates the parse
// state and loads one result into the output register, which shows it on
// the next cycle. in_ready is high whenever the output register is empty or
// being drained, so a stalled consumer holds off the producer by exactly one
// result. rst_n clears the parse state to the start of a file; end_of_stream
// does the same after its own result.
`timescale 1ns / 1ps

module wav_header_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        end_of_stream,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  stage,
    output logic [2:0]  error_code,
    output logic [15:0] channel_count,
    output logic [31:0] sample_rate,
    output logic [15:0] sample_bits,
    output logic [31:0] data_length,
    output logic        payload_valid,
    output logic [7:0]  payload_byte
);
    import wavhp_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    result_t step_res;
    result_t out_res;
    logic    in_xfer;

    assign in_xfer = in_valid && in_ready;

    // Per-byte parse logic
    wavhp_next u_next (
        .cur           (state_reg),
        .in_byte       (in_byte),
        .end_of_stream (end_of_stream),
        .nxt           (state_next),
        .res           (step_res)
    );

    // Parse state advances on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (in_xfer)
        begin
            state_reg <= state_next;
        end
    end

    // Output register
    wavhp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_xfer),
        .res_in    (step_res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .take_ok   (in_ready),
        .res_out   (out_res)
    );

    assign stage         = out_res.stage;
    assign error_code    = out_res.error_code;
    assign channel_count = out_res.channel_count;
    assign sample_rate   = out_res.sample_rate;
    assign sample_bits   = out_res.sample_bits;
    assign data_length   = out_res.data_length;
    assign payload_valid = out_res.payload_valid;
    assign payload_byte  = out_res.payload_byte;

endmodule

>>> hw/rtl/wavhp_checker.sv
// Port-level checks for the WAV header parser, bound to the top level.
`timescale 1ns / 1ps

module wavhp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  in_byte,
    input logic        end_of_stream,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  stage,
    input logic [2:0]  error_code,
    input logic [15:0] channel_count,
    input logic [31:0] sample_rate,
    input logic [15:0] sample_bits,
    input logic [31:0] data_length,
    input logic        payload_valid,
    input logic [7:0]  payload_byte
);
    import wavhp_pkg::*;

    // A stalled input transfer keeps its byte and end flag
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_byte) && $stable(end_of_stream))
        else $error("input changed while stalled");

    // A stalled result holds its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(stage) && $stable(error_code)
            && $stable(channel_count) && $stable(sample_rate) && $stable(sample_bits)
            && $stable(payload_valid) && $stable(payload_byte) && $stable(data_length))
        else $error("result changed while stalled");

    // Input never blocked while the result slot is empty
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // Payload flag agrees with stage and gates the byte
    a_payload_stage: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (payload_valid == (stage == STAGE_PAYLOAD))
            && (payload_valid || payload_byte == 8'd0))
        else $error("payload flag and stage disagree");

    // Error code only reported in the error stage, and never zero there
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((stage == STAGE_ERROR) == (error_code != ERR_NONE)))
        else $error("error code inconsistent with stage");

endmodule

bind wav_header_parser_core wavhp_checker u_wavhp_checker (.*);
